### hdl/tcw_pkg.sv
// Shared constants and codes for the text console writer.
package tcw_pkg;

    localparam int COLUMNS_DEF    = 80;
    localparam int ROWS_DEF       = 25;
    localparam int TAB_SPACES_DEF = 4;

    localparam int KIND_W = 2;
    localparam int BYTE_W = 8;
    localparam int ADDR_W = 11;
    localparam int POS_W  = 11;
    localparam int CELL_W = 16;

    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [BYTE_W-1:0] CH_TAB     = 8'd9;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'd32;
    localparam logic [BYTE_W-1:0] ATTR_RESET = 8'h0F;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

endpackage

### hdl/tcw_cell_ram.sv
// Simple dual-port cell store: one write port, one registered read port.
module tcw_cell_ram #(
    parameter int DEPTH  = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
    parameter int DATA_W = tcw_pkg::CELL_W
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);
    import tcw_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/text_console_writer_unit.sv
// Text console writer top level: cursor sequencer around the cell store.
//
// Item channel: drive i_kind, i_char_code and i_cell_address with start
// high; the item transfers at a rising edge where busy is low. Each item
// gives exactly one result (cursor position, read cell character and
// attribute) shown for one cycle with o_strobe high; the receiver cannot
// stall it and must take the transfer in that cycle.
// Config channel: i_cfg_data transfers into the attribute register when
// i_cfg_valid and o_cfg_ready are high; o_cfg_ready is always high.
// Busy falls in the strobe cycle, so the next item can transfer at the edge
// that ends the strobe. Each scroll moves one cell per cycle through the
// single read and write port.
// Reset: cursor home, attribute 0x0F, then a clearing pass over every cell
//   with busy high; config writes still transfer.
// One memory with a registered read port; every write goes through a
// one-entry request stage so scroll copies merge the read character with
// the current attribute.
module text_console_writer_unit #(
    parameter int COLUMNS    = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS       = tcw_pkg::ROWS_DEF,
    parameter int TAB_SPACES = tcw_pkg::TAB_SPACES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // item channel
    input  logic                        start,
    output logic                        busy,
    input  logic [tcw_pkg::KIND_W-1:0]  i_kind,
    input  logic [tcw_pkg::BYTE_W-1:0]  i_char_code,
    input  logic [tcw_pkg::ADDR_W-1:0]  i_cell_address,
    // result channel
    output logic                        o_strobe,
    output logic [tcw_pkg::POS_W-1:0]   o_cursor_position,
    output logic [tcw_pkg::BYTE_W-1:0]  o_cell_char,
    output logic [tcw_pkg::BYTE_W-1:0]  o_cell_attr,
    // attribute register
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tcw_pkg::BYTE_W-1:0]  i_cfg_data
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELL_COUNT);
    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);
    localparam int TAB_W = $clog2(TAB_SPACES + 1);
    localparam int XW    = (AW > ADDR_W) ? AW : ADDR_W;  // compare width
    localparam int PW    = (AW > POS_W) ? AW : POS_W;

    typedef enum logic [8:0] {
        S_INIT   = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_CHAR   = 9'b000000100,
        S_NL     = 9'b000001000,
        S_SCROLL = 9'b000010000,
        S_BLANK  = 9'b000100000,
        S_CLEAR  = 9'b001000000,
        S_RD     = 9'b010000000,
        S_FIN    = 9'b100000000
    } t_state;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_idx, n_idx;         // sweep pointer
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [AW-1:0]     r_pos, n_pos;         // row*COLUMNS+col
    logic [TAB_W-1:0]  r_tab, n_tab;         // characters still to place
    logic [BYTE_W-1:0] r_char, n_char;
    logic [AW-1:0]     r_addr, n_addr;
    logic              r_rd_ok, n_rd_ok;
    logic [BYTE_W-1:0] r_attr;

    // write request stage
    logic              r_wr_en, n_wr_en;
    logic [AW-1:0]     r_wr_addr, n_wr_addr;
    logic              r_wr_keep, n_wr_keep; // take character from read data
    logic [BYTE_W-1:0] r_wr_char, n_wr_char;
    logic [BYTE_W-1:0] r_wr_attr, n_wr_attr;

    // result registers
    logic              r_strobe;
    logic [AW-1:0]     r_out_pos;
    logic [BYTE_W-1:0] r_out_char;
    logic [BYTE_W-1:0] r_out_attr;

    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;
    logic [CELL_W-1:0] ram_wdata;
    logic [XW-1:0]     addr_ext;
    logic              addr_in_range;
    logic [PW-1:0]     pos_ext;
    logic              accept;
    logic              last_idx;

    tcw_cell_ram #(
        .DEPTH  (CELL_COUNT),
        .DATA_W (CELL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_wr_en),
        .i_waddr (r_wr_addr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ram_wdata = {r_wr_attr, r_wr_keep ? ram_rdata[BYTE_W-1:0] : r_wr_char};
    assign ram_raddr = (r_state == S_RD) ? r_addr : r_idx;

    assign addr_ext      = XW'(i_cell_address);
    assign addr_in_range = addr_ext < XW'(CELL_COUNT);
    assign accept        = start && !busy;
    assign last_idx      = r_idx == AW'(CELL_COUNT - 1);

    assign busy        = r_state != S_IDLE;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_col     = r_col;
        n_row     = r_row;
        n_pos     = r_pos;
        n_tab     = r_tab;
        n_char    = r_char;
        n_addr    = r_addr;
        n_rd_ok   = r_rd_ok;
        n_wr_en   = 1'b0;
        n_wr_addr = r_idx;
        n_wr_keep = 1'b0;
        n_wr_char = CH_SPACE;
        n_wr_attr = r_attr;

        case (r_state)
            S_INIT: begin
                n_wr_en   = 1'b1;
                n_wr_attr = ATTR_RESET;
                n_idx     = r_idx + AW'(1);
                if (last_idx) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_rd_ok = 1'b0;
                    case (t_kind'(i_kind))
                        KIND_WRITE: begin
                            if (i_char_code == CH_NEWLINE) begin
                                n_tab   = '0;
                                n_state = S_NL;
                            end else if (i_char_code == CH_TAB) begin
                                n_tab   = TAB_W'(TAB_SPACES);
                                n_char  = CH_SPACE;
                                n_state = S_CHAR;
                            end else begin
                                n_tab   = TAB_W'(1);
                                n_char  = i_char_code;
                                n_state = S_CHAR;
                            end
                        end
                        KIND_CLEAR: begin
                            n_idx   = '0;
                            n_state = S_CLEAR;
                        end
                        KIND_READ: begin
                            n_addr  = AW'(addr_ext);
                            n_rd_ok = addr_in_range;
                            n_state = addr_in_range ? S_RD : S_FIN;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_CHAR: begin
                n_wr_en   = 1'b1;
                n_wr_addr = r_pos;
                n_wr_char = r_char;
                n_tab     = r_tab - TAB_W'(1);
                n_state   = (n_tab != '0) ? S_CHAR : S_FIN;
                if (r_col == COL_W'(COLUMNS - 1)) begin
                    n_col = '0;
                    if (r_row == ROW_W'(ROWS - 1)) begin
                        n_idx   = AW'(COLUMNS);
                        n_state = S_SCROLL;
                    end else begin
                        n_row = r_row + ROW_W'(1);
                        n_pos = r_pos + AW'(1);
                    end
                end else begin
                    n_col = r_col + COL_W'(1);
                    n_pos = r_pos + AW'(1);
                end
            end
            S_NL: begin
                n_col = '0;
                if (r_row == ROW_W'(ROWS - 1)) begin
                    n_idx   = AW'(COLUMNS);
                    n_state = S_SCROLL;
                end else begin
                    n_row   = r_row + ROW_W'(1);
                    n_pos   = r_pos - AW'(r_col) + AW'(COLUMNS);
                    n_state = S_FIN;
                end
            end
            S_SCROLL: begin
                // read cell idx now, write it one row up next cycle
                n_wr_en   = 1'b1;
                n_wr_addr = r_idx - AW'(COLUMNS);
                n_wr_keep = 1'b1;
                n_idx     = r_idx + AW'(1);
                if (last_idx) begin
                    n_idx   = AW'(CELL_COUNT - COLUMNS);
                    n_state = S_BLANK;
                end
            end
            S_BLANK: begin
                n_wr_en = 1'b1;
                n_idx   = r_idx + AW'(1);
                if (last_idx) begin
                    n_row   = ROW_W'(ROWS - 1);
                    n_col   = '0;
                    n_pos   = AW'(CELL_COUNT - COLUMNS);
                    n_state = (r_tab != '0) ? S_CHAR : S_FIN;
                end
            end
            S_CLEAR: begin
                n_wr_en = 1'b1;
                n_idx   = r_idx + AW'(1);
                if (last_idx) begin
                    n_row   = '0;
                    n_col   = '0;
                    n_pos   = '0;
                    n_state = S_FIN;
                end
            end
            S_RD: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_idx    <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_pos    <= '0;
            r_tab    <= '0;
            r_rd_ok  <= 1'b0;
            r_wr_en  <= 1'b0;
            r_strobe <= 1'b0;
            r_attr   <= ATTR_RESET;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_col    <= n_col;
            r_row    <= n_row;
            r_pos    <= n_pos;
            r_tab    <= n_tab;
            r_rd_ok  <= n_rd_ok;
            r_wr_en  <= n_wr_en;
            r_strobe <= r_state == S_FIN;
            if (i_cfg_valid && o_cfg_ready) begin
                r_attr <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_char    <= n_char;
        r_addr    <= n_addr;
        r_wr_addr <= n_wr_addr;
        r_wr_keep <= n_wr_keep;
        r_wr_char <= n_wr_char;
        r_wr_attr <= n_wr_attr;
        if (r_state == S_FIN) begin
            r_out_pos  <= r_pos;
            r_out_char <= r_rd_ok ? ram_rdata[BYTE_W-1:0] : '0;
            r_out_attr <= r_rd_ok ? ram_rdata[CELL_W-1:BYTE_W] : '0;
        end
    end

    assign pos_ext           = PW'(r_out_pos);
    assign o_strobe          = r_strobe;
    assign o_cursor_position = pos_ext[POS_W-1:0];
    assign o_cell_char       = r_out_char;
    assign o_cell_attr       = r_out_attr;

endmodule

### dv/text_console_writer_checker.sv
// Checker for the text console writer: predicts every result and compares it.
module text_console_writer_checker #(
    parameter int COLUMNS    = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS       = tcw_pkg::ROWS_DEF,
    parameter int TAB_SPACES = tcw_pkg::TAB_SPACES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic [tcw_pkg::KIND_W-1:0] kind,
    input  logic [tcw_pkg::BYTE_W-1:0] char_code,
    input  logic [tcw_pkg::ADDR_W-1:0] cell_address,
    input  logic                       strobe,
    input  logic [tcw_pkg::POS_W-1:0]  cursor_position,
    input  logic [tcw_pkg::BYTE_W-1:0] cell_char,
    input  logic [tcw_pkg::BYTE_W-1:0] cell_attr,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [tcw_pkg::BYTE_W-1:0] cfg_data,
    output int                         mismatches,
    output int                         awaiting,
    output int                         scrolls
);
    timeunit 1ns;
    timeprecision 1ps;
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;

    typedef struct packed {
        logic [POS_W-1:0]  cursor;
        logic [BYTE_W-1:0] glyph;
        logic [BYTE_W-1:0] attr;
    } t_console_view;

    logic [CELL_W-1:0] screen [CELLS];
    int unsigned       cur_row;
    int unsigned       cur_col;
    logic [BYTE_W-1:0] text_attr;
    t_console_view     predicted_views [$];

    function void roll_screen();
        for (int i = 0; i < CELLS - COLUMNS; i++)
            screen[i] = {text_attr, screen[i + COLUMNS][BYTE_W-1:0]};
        for (int i = CELLS - COLUMNS; i < CELLS; i++)
            screen[i] = {text_attr, CH_SPACE};
        cur_row = ROWS - 1;
        cur_col = 0;
        scrolls++;
    endfunction

    function void lay_glyph(input logic [BYTE_W-1:0] glyph);
        screen[cur_row * COLUMNS + cur_col] = {text_attr, glyph};
        cur_col++;
        if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= ROWS)
            roll_screen();
    endfunction

    function t_console_view advance_console(input t_kind k, input logic [BYTE_W-1:0] glyph,
                                            input logic [ADDR_W-1:0] addr);
        t_console_view view;
        view = '0;
        case (k)
            KIND_WRITE: begin
                if (glyph == CH_NEWLINE) begin
                    cur_col = 0;
                    cur_row++;
                    if (cur_row >= ROWS)
                        roll_screen();
                end else if (glyph == CH_TAB) begin
                    for (int i = 0; i < TAB_SPACES; i++)
                        lay_glyph(CH_SPACE);
                end else begin
                    lay_glyph(glyph);
                end
            end
            KIND_CLEAR: begin
                for (int i = 0; i < CELLS; i++)
                    screen[i] = {text_attr, CH_SPACE};
                cur_row = 0;
                cur_col = 0;
            end
            KIND_READ: begin
                // out-of-range reads give zero fields
                if (addr < CELLS)
                    {view.attr, view.glyph} = screen[addr];
            end
            default: ;
        endcase
        view.cursor = POS_W'(cur_row * COLUMNS + cur_col);
        return view;
    endfunction

    always @(posedge i_clk) begin : watch
        t_console_view want;
        t_console_view got;
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++)
                screen[i] = {ATTR_RESET, CH_SPACE};
            cur_row = 0;
            cur_col = 0;
            text_attr = ATTR_RESET;
            predicted_views.delete();
        end else begin
            // compare before queuing: a new item can transfer on the strobe edge
            if (strobe) begin
                got = {cursor_position, cell_char, cell_attr};
                if (predicted_views.size() == 0) begin
                    $display("%0t: unexpected result cursor %0d char %02h attr %02h",
                             $time, got.cursor, got.glyph, got.attr);
                    mismatches++;
                end else begin
                    want = predicted_views.pop_front();
                    if (got.cursor !== want.cursor || got.glyph !== want.glyph ||
                        got.attr !== want.attr) begin
                        $display("%0t: cursor/char/attr expected %0d/%02h/%02h got %0d/%02h/%02h",
                                 $time, want.cursor, want.glyph, want.attr,
                                 got.cursor, got.glyph, got.attr);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                text_attr = cfg_data;
            if (start && !busy)
                predicted_views.push_back(advance_console(t_kind'(kind), char_code, cell_address));
        end
        awaiting = predicted_views.size();
    end

endmodule

### dv/text_console_writer_unit_tb.sv
// Testbench top for the text console writer: stimulus, reset and verdict.
module text_console_writer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tcw_pkg::*;

    localparam int CELLS           = COLUMNS_DEF * ROWS_DEF;
    // counted (non-ignored) items per random phase, three phases
    localparam int ITEMS_PER_PHASE = 460;
    // Slowest item is one that scrolls or clears the whole store. The limit
    // allows four times the cost of every item being that slow, plus the reset pass.
    localparam int CYCLE_LIMIT     = 12_000_000;
    localparam int TAIL_CYCLES     = 16;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [KIND_W-1:0] item_kind;
    logic [BYTE_W-1:0] item_char;
    logic [ADDR_W-1:0] item_addr;
    logic              strobe;
    logic [POS_W-1:0]  cursor_pos;
    logic [BYTE_W-1:0] read_char;
    logic [BYTE_W-1:0] read_attr;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [BYTE_W-1:0] cfg_data;

    int mismatches;
    int awaiting;
    int scrolls;

    // stimulus bookkeeping
    int               idle_pct;
    int               write_items;
    int               clear_items;
    int               read_items;
    int               ignored_items;
    int               attr_writes;
    logic [POS_W-1:0] last_cursor;

    text_console_writer_unit uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_kind            (item_kind),
        .i_char_code       (item_char),
        .i_cell_address    (item_addr),
        .o_strobe          (strobe),
        .o_cursor_position (cursor_pos),
        .o_cell_char       (read_char),
        .o_cell_attr       (read_attr),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_data        (cfg_data)
    );

    text_console_writer_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .kind            (item_kind),
        .char_code       (item_char),
        .cell_address    (item_addr),
        .strobe          (strobe),
        .cursor_position (cursor_pos),
        .cell_char       (read_char),
        .cell_attr       (read_attr),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .awaiting        (awaiting),
        .scrolls         (scrolls)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hang guard: a stuck busy or a lost result ends the run here.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("%0t: cycle limit reached, %0d results outstanding", $time, awaiting);
        $display("Test completed with failures");
        $finish;
    end

    // Latest cursor seen on the result port; read addresses are picked near it
    // so that reads mostly land on freshly written text. It lags one item.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            last_cursor <= '0;
        else if (strobe)
            last_cursor <= cursor_pos;
    end

    // One item transfer. Called at a falling edge, returns at a falling edge.
    // Optional idle gaps come first with start low; start is then held high
    // until the edge where busy is low.
    task automatic issue(input t_kind k, input logic [BYTE_W-1:0] ch,
                         input logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start     <= 1'b1;
        item_kind <= k;
        item_char <= ch;
        item_addr <= addr;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        case (k)
            KIND_WRITE: write_items++;
            KIND_CLEAR: clear_items++;
            KIND_READ:  read_items++;
            default:    ignored_items++;
        endcase
    endtask

    // Attribute writes happen only with the block idle: every result back.
    // Each item gives exactly one result and busy drops in its strobe cycle,
    // so an empty expectation store means nothing is in flight.
    task automatic set_attribute(input logic [BYTE_W-1:0] value);
        start <= 1'b0;
        while (awaiting != 0) @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        attr_writes++;
    endtask

    // Mostly printable text; now and then any byte at all (tab and newline too).
    function automatic logic [BYTE_W-1:0] text_byte();
        if ($urandom_range(9) == 0)
            return BYTE_W'($urandom_range(0, 255));
        return BYTE_W'($urandom_range(32, 126));
    endfunction

    // Read address: usually just behind the cursor, sometimes anywhere,
    // sometimes at or past the end of the store (address bit 10 gets exercised too).
    function automatic logic [ADDR_W-1:0] read_address();
        int back;
        case ($urandom_range(9))
            0:       return ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
            1:       return ADDR_W'($urandom_range(CELLS - 1, (1 << ADDR_W) - 1));
            default: begin
                back = $urandom_range(0, 200);
                if (int'(last_cursor) >= back)
                    return ADDR_W'(int'(last_cursor) - back);
                return ADDR_W'($urandom_range(0, CELLS - 1));
            end
        endcase
    endfunction

    // Short hand-picked opening: field extremes, every kind, attribute extremes.
    task automatic run_directed();
        issue(KIND_READ, 8'h00, 11'd0);               // reset content, first cell
        issue(KIND_READ, 8'h00, ADDR_W'(CELLS - 1));  // last cell
        issue(KIND_READ, 8'h00, ADDR_W'(CELLS));      // first address past the store
        issue(KIND_READ, 8'hFF, 11'h7FF);             // top address, all bits set
        issue(KIND_WRITE, 8'h41, 11'd0);
        issue(KIND_WRITE, 8'h00, 11'h7FF);
        issue(KIND_WRITE, 8'hFF, 11'd0);
        issue(KIND_WRITE, CH_TAB, 11'd0);
        issue(KIND_WRITE, CH_NEWLINE, 11'd0);
        issue(KIND_NONE, 8'hFF, 11'h7FF);             // unused kind, ignored
        issue(KIND_READ, 8'h00, 11'd0);
        issue(KIND_READ, 8'h00, 11'd2);
        issue(KIND_READ, 8'h00, 11'd3);               // first tab space
        set_attribute(8'h00);
        issue(KIND_WRITE, 8'h55, 11'd0);
        issue(KIND_READ, 8'h00, ADDR_W'(COLUMNS_DEF));
        issue(KIND_CLEAR, 8'h00, 11'd0);
        issue(KIND_READ, 8'h00, 11'd0);
        issue(KIND_READ, 8'h00, ADDR_W'(CELLS - 1));
        set_attribute(8'hFF);
        issue(KIND_WRITE, 8'hAA, 11'd0);
        issue(KIND_WRITE, CH_NEWLINE, 11'd0);
        issue(KIND_READ, 8'h00, 11'd0);
        issue(KIND_READ, 8'h00, 11'd1);
    endtask

    // Random part: mostly well-formed text (lines, wraps, tabs at row end)
    // so the cursor reaches the bottom and scrolls, mixed with reads, clears
    // and noise items. Ignored items do not count toward the target.
    task automatic run_random(input int target, input int pct);
        int goal;
        int n;
        idle_pct = pct;
        goal = write_items + clear_items + read_items + target;
        while (write_items + clear_items + read_items < goal) begin
            n = $urandom_range(99);
            if (n < 45) begin
                // a line of text, sometimes longer than a row, usually ended
                repeat ($urandom_range(0, 90)) begin
                    if ($urandom_range(15) == 0)
                        issue(KIND_WRITE, CH_TAB, ADDR_W'($urandom()));
                    else
                        issue(KIND_WRITE, text_byte(), ADDR_W'($urandom()));
                end
                if ($urandom_range(4) != 0)
                    issue(KIND_WRITE, CH_NEWLINE, ADDR_W'($urandom()));
            end else if (n < 57) begin
                // fill a row to its last few columns, then tab across the end
                issue(KIND_WRITE, CH_NEWLINE, ADDR_W'($urandom()));
                repeat ($urandom_range(COLUMNS_DEF - 4, COLUMNS_DEF - 1))
                    issue(KIND_WRITE, text_byte(), ADDR_W'($urandom()));
                issue(KIND_WRITE, CH_TAB, ADDR_W'($urandom()));
            end else if (n < 80) begin
                repeat ($urandom_range(1, 4))
                    issue(KIND_READ, BYTE_W'($urandom()), read_address());
            end else if (n < 83) begin
                issue(KIND_CLEAR, BYTE_W'($urandom()), ADDR_W'($urandom()));
            end else begin
                // noise: any kind with arbitrary fields
                issue(t_kind'($urandom_range(0, 3)), BYTE_W'($urandom()),
                      ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1)));
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        start         = 1'b0;
        item_kind     = KIND_WRITE;
        item_char     = '0;
        item_addr     = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        idle_pct      = 32;
        write_items   = 0;
        clear_items   = 0;
        read_items    = 0;
        ignored_items = 0;
        attr_writes   = 0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // the block sweeps the store after reset with busy high
        @(negedge i_clk);
        while (busy !== 1'b0) @(negedge i_clk);

        run_directed();

        // sender idles about a third of the time
        set_attribute(BYTE_W'($urandom()));
        run_random(ITEMS_PER_PHASE, 32);
        // sender idles about half the time
        set_attribute(BYTE_W'($urandom()));
        run_random(ITEMS_PER_PHASE, 51);
        // back to back
        set_attribute(BYTE_W'($urandom()));
        run_random(ITEMS_PER_PHASE, 0);

        start <= 1'b0;
        while (awaiting != 0) @(negedge i_clk);
        // run on for TAIL_CYCLES so a stray extra result would still be caught
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Covered %0d character writes, %0d clears, %0d cell reads, %0d unused-kind items",
                 write_items, clear_items, read_items, ignored_items);
        $display("Screen scrolled %0d times over %0d attribute settings, %0d mismatches",
                 scrolls, attr_writes, mismatches);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
